### rtl/core/pps_pkg.sv
// Shared types, constants and codes of the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

    // Table geometry.
    localparam int SLOTS   = 16;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Field widths and saturation limits.
    localparam int TIME_W = 24;
    localparam int SUM_W  = 28;
    localparam int CFG_W  = 5;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CFG_W-1:0]  COUNT_MAX = {CFG_W{1'b1}};

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // One slot of the task table as it sits in memory.
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [7:0]        prio;
        logic [15:0]       remaining;
        logic [15:0]       burst;
        logic [15:0]       arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### rtl/core/pps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: task table, scan sequencer and result stage.
//
//  channel   | direction | handshake              | contents
//  ----------+-----------+------------------------+-------------------------------------
//  s_        | in        | s_tvalid / s_tready    | op in tuser, task data in tdata
//  m_        | out       | m_tvalid / m_tready    | one result word per tick
//  cfg_      | in        | cfg_valid / cfg_ready  | active_count
//
// Clear and load words are taken in the idle state. After a tick is accepted, the scan reads
// one slot a cycle from the table memory and then compares the last slot read; the update
// state then writes the chosen slot back and the emit state moves the result into the
// output register, as the input turns ready again.
// Reset empties the table at once through per-slot valid bits. A stalled result holds
// the block in its last state; a waiting result does not block clear or load words.
`default_nettype none

module preemptive_priority_scheduler (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input words.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: slot[3:0], arrival_time[19:4], burst_time[35:20], priority_req[43:36], zeros
    input  wire logic [47:0]  s_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_tuser,
    // Result words.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: time_now[23:0], run_slot[27:24], start_time[51:28], finish_time[75:52],
    //        turnaround_time[99:76], waiting_time[123:100], total_waiting[151:124],
    //        total_turnaround[179:152], all_done[180], zeros
    output logic      [183:0] m_tdata,
    // tuser: idle[0], finished[1]
    output logic      [1:0]   m_tuser,
    // Configuration: active_count.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [pps_pkg::CFG_W-1:0] cfg_data
);

    import pps_pkg::*;

    // Input field unpacking.
    logic [1:0]  in_op;
    logic [3:0]  in_slot;
    logic [15:0] in_arrival;
    logic [15:0] in_burst;
    logic [7:0]  in_prio;
    logic        s_accept;

    assign in_op      = s_tuser;
    assign in_slot    = s_tdata[3:0];
    assign in_arrival = s_tdata[19:4];
    assign in_burst   = s_tdata[35:20];
    assign in_prio    = s_tdata[43:36];
    assign s_accept   = s_tvalid && s_tready;

    // Control and state registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg;
    logic               pend_reg;
    logic [SLOT_AW-1:0] pidx_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               have_pick_reg;
    logic [SLOT_AW-1:0] best_idx_reg;
    entry_t             best_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CFG_W-1:0]   count_reg;
    logic [SUM_W-1:0]   wsum_reg;
    logic [SUM_W-1:0]   tsum_reg;
    logic [CFG_W-1:0]   active_reg;
    logic               ran_reg;
    logic               fin_reg;
    logic [SLOT_AW-1:0] run_reg;
    logic [TIME_W-1:0]  st_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  wt_reg;
    logic               m_valid_reg;
    logic [183:0]       m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // Memory port signals.
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    pps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Number of slots a tick scans.
    logic [CNT_W-1:0] scan_lim;
    always_comb begin
        if (int'(active_reg) < SLOTS) begin
            scan_lim = CNT_W'(active_reg);
        end else begin
            scan_lim = CNT_W'(SLOTS);
        end
    end

    // Scan comparator: does the slot just read beat the best so far?
    entry_t cand;
    logic   take;
    always_comb begin
        cand = entry_t'(ram_rdata);
        take = pend_reg && valid_reg[pidx_reg] && (cand.remaining != 16'd0) &&
               ({8'd0, cand.arrival} <= time_reg) &&
               (!have_pick_reg || (cand.prio < best_reg.prio) ||
                ((cand.prio == best_reg.prio) && (cand.arrival < best_reg.arrival)));
    end

    // Update of the chosen slot and the figures of a completion.
    entry_t            upd_ent;
    logic [TIME_W-1:0] time_next;
    logic              fin_c;
    logic [TIME_W-1:0] tat_c;
    logic [TIME_W-1:0] wt_c;
    always_comb begin
        upd_ent = best_reg;
        if (best_reg.remaining == best_reg.burst) begin
            upd_ent.start = time_reg;
        end
        upd_ent.remaining = best_reg.remaining - 16'd1;
        if (time_reg == TIME_MAX) begin
            time_next = time_reg;
        end else begin
            time_next = time_reg + 24'd1;
        end
        fin_c = have_pick_reg && (best_reg.remaining == 16'd1);
        tat_c = time_next - {8'd0, best_reg.arrival};
        if (tat_c > {8'd0, best_reg.burst}) begin
            wt_c = tat_c - {8'd0, best_reg.burst};
        end else begin
            wt_c = '0;
        end
    end

    // Running totals as they stand after this result.
    logic              out_free;
    logic [SUM_W:0]    wsum_add;
    logic [SUM_W:0]    tsum_add;
    logic [SUM_W-1:0]  wsum_next;
    logic [SUM_W-1:0]  tsum_next;
    logic [CFG_W-1:0]  count_next;
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        wsum_add = {1'b0, wsum_reg} + {{(SUM_W + 1 - TIME_W){1'b0}}, wt_reg};
        tsum_add = {1'b0, tsum_reg} + {{(SUM_W + 1 - TIME_W){1'b0}}, tat_reg};
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        count_next = count_reg;
        if (fin_reg) begin
            wsum_next  = wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
            tsum_next  = tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 5'd1;
        end
    end

    // Sequencer: next state and memory port control.
    always_comb begin
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = SLOT_AW'(in_slot);
        ram_wdata  = '{start: '0, prio: in_prio, remaining: in_burst,
                       burst: in_burst, arrival: in_arrival};
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[SLOT_AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_op == OP_LOAD) && (int'(in_slot) < SLOTS)) begin
                    ram_we = 1'b1;
                end
                if (s_accept && (in_op == OP_TICK)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg < scan_lim) begin
                    ram_re = 1'b1;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (have_pick_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = upd_ent;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control state: valid bits, time, totals, scan progress, output handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            time_reg      <= '0;
            count_reg     <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            active_reg    <= 5'd1;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            have_pick_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            // Output valid is set when a result word is written and cleared when it is taken.
            if ((state_reg == ST_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            pend_reg <= ram_re;
            if (take) begin
                have_pick_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg       <= '0;
                    have_pick_reg <= 1'b0;
                    if (s_accept && (in_op == OP_CLEAR)) begin
                        valid_reg <= '0;
                        time_reg  <= '0;
                        count_reg <= '0;
                        wsum_reg  <= '0;
                        tsum_reg  <= '0;
                    end
                    if (ram_we) begin
                        valid_reg[ram_waddr] <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (ram_re) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_UPD: begin
                    time_reg <= time_next;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        wsum_reg    <= wsum_next;
                        tsum_reg    <= tsum_next;
                        count_reg   <= count_next;
                    end
                end
                default: begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    // Payload: best candidate, completion figures and the output word.
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            pidx_reg <= ram_raddr;
        end
        if (take) begin
            best_reg     <= cand;
            best_idx_reg <= pidx_reg;
        end
        if (state_reg == ST_UPD) begin
            ran_reg <= have_pick_reg;
            fin_reg <= fin_c;
            run_reg <= have_pick_reg ? best_idx_reg : '0;
            st_reg  <= fin_c ? upd_ent.start : '0;
            tat_reg <= fin_c ? tat_c : '0;
            wt_reg  <= fin_c ? wt_c : '0;
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            m_tdata_reg <= {3'd0,
                            (count_next >= active_reg),
                            tsum_next,
                            wsum_next,
                            wt_reg,
                            tat_reg,
                            fin_reg ? time_reg : 24'd0,
                            st_reg,
                            4'(run_reg),
                            time_reg};
            m_tuser_reg <= {fin_reg, !ran_reg};
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
